// ----- hw/rtl/lus_pkg.sv -----
`default_nettype none

package lus_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_ITEMS = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	// event codes
	localparam logic [2:0] FN_START   = 3'd0;
	localparam logic [2:0] FN_READ    = 3'd1;
	localparam logic [2:0] FN_ACK     = 3'd2;
	localparam logic [2:0] FN_TIMEOUT = 3'd3;
	localparam logic [2:0] FN_CANCEL  = 3'd4;

	// message kinds
	localparam logic [1:0] SK_NONE   = 2'd0;
	localparam logic [1:0] SK_COUNT  = 2'd1;
	localparam logic [1:0] SK_ITEM   = 2'd2;
	localparam logic [1:0] SK_CANCEL = 2'd3;

	// timer commands
	localparam logic [1:0] TM_NONE    = 2'd0;
	localparam logic [1:0] TM_START   = 2'd1;
	localparam logic [1:0] TM_REFRESH = 2'd2;
	localparam logic [1:0] TM_STOP    = 2'd3;

	// exchange status
	localparam logic [2:0] ST_SUCCESS   = 3'd0;
	localparam logic [2:0] ST_CONN_ERR  = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_TIMEOUT   = 3'd3;
	localparam logic [2:0] ST_PROTO_ERR = 3'd4;

	localparam logic [7:0] ACK_LAST_KNOWN = 8'd13;
	localparam logic [3:0] ACK_UNKNOWN    = 4'd14;
	localparam logic [3:0] SENDS_MAX      = 4'd15;

	// configuration register indexes
	localparam logic [7:0] CFG_ITEM_COUNT  = 8'd0;
	localparam logic [7:0] CFG_RETRY_LIMIT = 8'd1;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] req_seq;
		logic [7:0]  ack_type;
		logic        link_accept;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  send_kind;
		logic [15:0] send_value;
		logic [1:0]  timer_cmd;
		logic        done_res;
		logic [2:0]  status;
		logic [3:0]  ack_code;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] next_item;
		logic [3:0]  sends_done;
		logic [3:0]  last_ack;
	} seq_state_t;

	typedef struct packed {
		logic [15:0] item_count;
		logic [3:0]  retry_limit;
	} seq_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lus_step.sv -----
`default_nettype none

module lus_step (
	input  lus_pkg::seq_state_t cur,
	input  lus_pkg::seq_cfg_t   cfg,
	input  lus_pkg::in_item_t   item,
	output lus_pkg::seq_state_t nxt,
	output lus_pkg::out_item_t  res
);
	import lus_pkg::*;

	always_comb begin
		logic        active;
		logic [3:0]  sd;
		logic [15:0] ni;
		active = (cur.phase == PH_COUNT) || (cur.phase == PH_ITEMS);
		sd     = cur.sends_done;
		ni     = cur.next_item;
		nxt    = cur;
		res    = '0;

		case (item.func)
			FN_START: begin
				nxt.last_ack   = ACK_UNKNOWN;
				nxt.phase      = PH_COUNT;
				nxt.next_item  = '0;
				res.send_kind  = SK_COUNT;
				res.send_value = cfg.item_count;
				if (!item.link_accept) begin
					res.timer_cmd  = TM_STOP;
					res.done_res   = 1'b1;
					res.status     = ST_CONN_ERR;
					nxt.phase      = PH_DONE;
					nxt.sends_done = '0;
				end else begin
					res.timer_cmd  = TM_START;
					nxt.sends_done = 4'd1;
				end
			end
			FN_READ: begin
				if (active) begin
					nxt.phase = PH_ITEMS;
					if (item.req_seq > cur.next_item) begin
						// ahead of expected: drop
					end else if (item.req_seq < cur.next_item &&
							cur.sends_done >= cfg.retry_limit) begin
						res.timer_cmd = TM_STOP;
						res.done_res  = 1'b1;
						res.status    = ST_TIMEOUT;
						nxt.phase     = PH_DONE;
					end else begin
						if (item.req_seq == cur.next_item)
							sd = '0;
						res.timer_cmd = TM_REFRESH;
						ni = item.req_seq;
						if (item.req_seq < cfg.item_count) begin
							res.send_kind  = SK_ITEM;
							res.send_value = item.req_seq;
							ni = item.req_seq + 16'd1;
							if (!item.link_accept) begin
								res.timer_cmd = TM_STOP;
								res.done_res  = 1'b1;
								res.status    = ST_CONN_ERR;
								nxt.phase     = PH_DONE;
							end else if (sd != SENDS_MAX) begin
								sd = sd + 4'd1;
							end
						end
						nxt.sends_done = sd;
						nxt.next_item  = ni;
					end
				end
			end
			FN_ACK: begin
				if (active) begin
					res.timer_cmd = TM_STOP;
					nxt.last_ack  = (item.ack_type <= ACK_LAST_KNOWN) ?
						item.ack_type[3:0] : ACK_UNKNOWN;
					res.done_res  = 1'b1;
					res.status    = (cur.next_item == cfg.item_count) ?
						ST_SUCCESS : ST_PROTO_ERR;
					nxt.phase     = PH_DONE;
				end
			end
			FN_TIMEOUT: begin
				if (active) begin
					if (cur.sends_done >= cfg.retry_limit || cur.phase == PH_ITEMS) begin
						// timer already expired: no command
						res.done_res = 1'b1;
						res.status   = ST_TIMEOUT;
						nxt.phase    = PH_DONE;
					end else begin
						res.send_kind  = SK_COUNT;
						res.send_value = cfg.item_count;
						if (!item.link_accept) begin
							res.timer_cmd = TM_STOP;
							res.done_res  = 1'b1;
							res.status    = ST_CONN_ERR;
							nxt.phase     = PH_DONE;
						end else begin
							res.timer_cmd = TM_START;
							if (sd != SENDS_MAX)
								nxt.sends_done = sd + 4'd1;
						end
					end
				end
			end
			FN_CANCEL: begin
				if (active) begin
					res.timer_cmd = TM_STOP;
					res.send_kind = SK_CANCEL;
					res.done_res  = 1'b1;
					res.status    = item.link_accept ? ST_CANCELLED : ST_CONN_ERR;
					nxt.phase     = PH_DONE;
				end
			end
			default: begin
				// unused event codes: ignore
			end
		endcase

		res.ack_code = nxt.last_ack;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/list_upload_sequencer_top.sv -----
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        to block   in_valid/in_stall  in_data   (func, req_seq, ack_type, link_accept)
// out       from block out_valid/out_stall out_data (send_kind .. ack_code)
// cfg       to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One result per event, through an input register and then the decision logic
// into the result register. One event per cycle sustained while out is not
// stalled; the sequencer state advances when an event enters the result register.
// Reset clears the state to idle, item_count 0, retry_limit 4, last ack unknown.
// A stall on out backs up into in_stall only when both registers are full.

module list_upload_sequencer_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  lus_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output lus_pkg::out_item_t  out_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [7:0]          cfg_index,
	input  wire  [15:0]         cfg_data
);
	import lus_pkg::*;

	seq_cfg_t   cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res_nxt;
	logic       s2_free;
	logic       adv;

	assign cfg_ready = 1'b1;
	assign s2_free   = !out_valid || !out_stall;
	assign adv       = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.item_count  <= '0;
			cfg_q.retry_limit <= 4'd4;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ITEM_COUNT)
				cfg_q.item_count <= cfg_data;
			else if (cfg_index == CFG_RETRY_LIMIT)
				cfg_q.retry_limit <= cfg_data[3:0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	lus_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// sequencer state advances with each transaction into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.next_item  <= '0;
			state_q.sends_done <= '0;
			state_q.last_ack   <= ACK_UNKNOWN;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (s2_free)
			out_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_data <= res_nxt;
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a held item");

	a_done_enters_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.done_res) |=> (state_q.phase == PH_DONE))
		else $error("exchange ended but phase not finished");

	a_status_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.done_res) |-> (out_data.status == ST_SUCCESS))
		else $error("status set on a result that does not end the exchange");

	a_ack_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_data.ack_code == state_q.last_ack))
		else $error("result ack code differs from latched ack");

endmodule

`default_nettype wire
